/* rtl/mbcrc_pkg.sv */
package mbcrc_pkg;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // n / 10 == (n * 52429) >> 19 for every 16-bit n
  localparam logic [16:0] DivTenMul   = 17'd52429;
  localparam int          DivTenShift = 19;

  // Configuration register indexes
  localparam logic [1:0] RegRegisterCount = 2'd0;
  localparam logic [1:0] RegDivideByTen   = 2'd1;

  // One finished frame
  typedef struct packed {
    logic        done;
    logic        ok;
    logic [15:0] first;
    logic [15:0] second;
  } frame_result_t;

  // One byte of reflected CRC-16, eight shift steps unrolled
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/mbcrc_frame.sv */
module mbcrc_frame
  import mbcrc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    rx_byte,
  input  logic          abort,
  input  logic          two,
  output frame_result_t result
);

  logic [15:0] running_crc, running_crc_next;
  logic [3:0]  byte_position, byte_position_next;
  logic [15:0] first_register, first_register_next;
  logic [15:0] second_register, second_register_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;

  logic [3:0]  crc_pos;
  logic        in_body;
  logic        at_low;
  logic        crc_match;

  // Position of the CRC low byte: 5 for one register, 7 for two
  assign crc_pos   = two ? 4'd7 : 4'd5;
  assign in_body   = byte_position < crc_pos;
  assign at_low    = byte_position == crc_pos;
  assign crc_match = {rx_byte, crc_low_byte} == running_crc;

  always_comb begin
    running_crc_next     = running_crc;
    byte_position_next   = byte_position;
    first_register_next  = first_register;
    second_register_next = second_register;
    crc_low_byte_next    = crc_low_byte;
    result               = '0;
    if (abort) begin
      result.done          = 1'b1;
      running_crc_next     = CrcInit;
      byte_position_next   = '0;
      first_register_next  = '0;
      second_register_next = '0;
      crc_low_byte_next    = '0;
    end else if (in_body) begin
      running_crc_next   = crc_byte(running_crc, rx_byte);
      byte_position_next = byte_position + 4'd1;
      case (byte_position)
        4'd3:    first_register_next  = {rx_byte, first_register[7:0]};
        4'd4:    first_register_next  = {first_register[15:8], rx_byte};
        4'd5:    second_register_next = {rx_byte, second_register[7:0]};
        4'd6:    second_register_next = {second_register[15:8], rx_byte};
        default: ;
      endcase
    end else if (at_low) begin
      crc_low_byte_next  = rx_byte;
      byte_position_next = byte_position + 4'd1;
    end else begin
      result.done          = 1'b1;
      result.ok            = crc_match;
      result.first         = crc_match ? first_register : 16'd0;
      result.second        = (crc_match && two) ? second_register : 16'd0;
      running_crc_next     = CrcInit;
      byte_position_next   = '0;
      first_register_next  = '0;
      second_register_next = '0;
      crc_low_byte_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc     <= CrcInit;
      byte_position   <= '0;
      first_register  <= '0;
      second_register <= '0;
      crc_low_byte    <= '0;
    end else if (accept) begin
      running_crc     <= running_crc_next;
      byte_position   <= byte_position_next;
      first_register  <= first_register_next;
      second_register <= second_register_next;
      crc_low_byte    <= crc_low_byte_next;
    end
  end

endmodule

/* rtl/modbus_response_crc_checker.sv */
// Modbus RTU read-register response checker. Feed the response one byte per
// transaction on the s_axis side; raise s_axis_tuser to abort the frame
// (the byte is dropped and a failure result is sent). The block accepts one
// byte every cycle as long as the output side keeps up: the CRC-16 update
// (reflected 0xA001, start 0xFFFF) is unrolled over the eight bit steps of a
// byte, so every byte finishes in the cycle it is accepted. The frame is 7
// bytes with one register and 9 bytes with two; on the last byte (or an
// abort) one result transaction is produced through a result register, the
// divide-by-ten logic (a 16x17 reciprocal multiply) and an output register. A
// result carries ok in m_axis_tuser and both register values in
// m_axis_tdata; values are zero when ok is low. The result path holds two
// entries, so input stalls only when both are full and m_axis_tready is low.
// Configuration writes are always accepted; change them only between frames.
module modbus_response_crc_checker
  import mbcrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data,
  // received bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] abort
  // check results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] first_value, [31:16] second_value
  output logic        m_axis_tuser    // [0] ok
);

  logic [1:0] register_count;
  logic       divide_by_ten;

  logic          in_accept;
  frame_result_t frame_result;

  // result register (raw values)
  logic          raw_valid;
  logic          raw_ok;
  logic [15:0]   raw_first;
  logic [15:0]   raw_second;

  logic          out_free;
  logic          raw_move;
  logic [32:0]   first_prod;
  logic [32:0]   second_prod;
  logic [15:0]   first_scaled;
  logic [15:0]   second_scaled;

  // Configuration registers, written whenever offered
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      register_count <= 2'd1;
      divide_by_ten  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegRegisterCount: register_count <= cfg_data;
        RegDivideByTen:   divide_by_ten  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance the result register into the output register when it is free
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign raw_move      = raw_valid && out_free;
  assign s_axis_tready = !raw_valid || out_free;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  mbcrc_frame u_frame (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_accept),
    .rx_byte (s_axis_tdata),
    .abort   (s_axis_tuser),
    .two     (register_count[1]),
    .result  (frame_result)
  );

  // Capture a finished frame; hold it while the output side is full
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_valid <= 1'b0;
    end else if (in_accept) begin
      raw_valid <= frame_result.done;
    end else if (raw_move) begin
      raw_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && frame_result.done) begin
      raw_ok     <= frame_result.ok;
      raw_first  <= frame_result.first;
      raw_second <= frame_result.second;
    end
  end

  // Divide by ten through the reciprocal multiply; the quotient fits in 13 bits
  assign first_prod    = {17'd0, raw_first} * {16'd0, DivTenMul};
  assign second_prod   = {17'd0, raw_second} * {16'd0, DivTenMul};
  assign first_scaled  = divide_by_ten ? {3'd0, first_prod[DivTenShift +: 13]} : raw_first;
  assign second_scaled = divide_by_ten ? {3'd0, second_prod[DivTenShift +: 13]} : raw_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= raw_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (raw_move) begin
      m_axis_tdata <= {second_scaled, first_scaled};
      m_axis_tuser <= raw_ok;
    end
  end

endmodule
